// ----- sv/smlp_pkg.sv -----
// ----------------------------------------------------------------------------
// smlp_pkg
// Shared constants, codes and name tables for the SIP method list parser.
// ----------------------------------------------------------------------------
package smlp_pkg;

  localparam int DEF_MAX_METHODS = 16;
  localparam int DEF_OFFSET_BITS = 12;

  localparam int NAME_MAX = 9;

  localparam logic [3:0] METHOD_ACK       = 4'd0;
  localparam logic [3:0] METHOD_BYE       = 4'd1;
  localparam logic [3:0] METHOD_CANCEL    = 4'd2;
  localparam logic [3:0] METHOD_INFO      = 4'd3;
  localparam logic [3:0] METHOD_INVITE    = 4'd4;
  localparam logic [3:0] METHOD_MESSAGE   = 4'd5;
  localparam logic [3:0] METHOD_NOTIFY    = 4'd6;
  localparam logic [3:0] METHOD_OPTIONS   = 4'd7;
  localparam logic [3:0] METHOD_PRACK     = 4'd8;
  localparam logic [3:0] METHOD_PUBLISH   = 4'd9;
  localparam logic [3:0] METHOD_REFER     = 4'd10;
  localparam logic [3:0] METHOD_REGISTER  = 4'd11;
  localparam logic [3:0] METHOD_SUBSCRIBE = 4'd12;
  localparam logic [3:0] METHOD_UPDATE    = 4'd13;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_INVALID  = 2'd1;
  localparam logic [1:0] STATUS_TOO_MANY = 2'd2;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_V     = 8'h56;
  localparam logic [7:0] CH_U     = 8'h55;
  localparam logic [7:0] CH_G     = 8'h47;

  typedef struct packed {
    logic       hit;
    logic [3:0] code;
  } first_letter_t;

  function automatic logic [3:0] name_len(input logic [3:0] m);
    logic [3:0] len;
    case (m)
      METHOD_ACK:       len = 4'd3;
      METHOD_BYE:       len = 4'd3;
      METHOD_CANCEL:    len = 4'd6;
      METHOD_INFO:      len = 4'd4;
      METHOD_INVITE:    len = 4'd6;
      METHOD_MESSAGE:   len = 4'd7;
      METHOD_NOTIFY:    len = 4'd6;
      METHOD_OPTIONS:   len = 4'd7;
      METHOD_PRACK:     len = 4'd5;
      METHOD_PUBLISH:   len = 4'd7;
      METHOD_REFER:     len = 4'd5;
      METHOD_REGISTER:  len = 4'd8;
      METHOD_SUBSCRIBE: len = 4'd9;
      METHOD_UPDATE:    len = 4'd6;
      default:          len = 4'd0;
    endcase
    return len;
  endfunction

  // Character i of name m; first character in the top byte.
  function automatic logic [7:0] name_char(input logic [3:0] m, input logic [3:0] i);
    logic [8*NAME_MAX-1:0] str;
    logic [7:0]            ch;
    case (m)
      METHOD_ACK:       str = {"ACK", 48'h0};
      METHOD_BYE:       str = {"BYE", 48'h0};
      METHOD_CANCEL:    str = {"CANCEL", 24'h0};
      METHOD_INFO:      str = {"INFO", 40'h0};
      METHOD_INVITE:    str = {"INVITE", 24'h0};
      METHOD_MESSAGE:   str = {"MESSAGE", 16'h0};
      METHOD_NOTIFY:    str = {"NOTIFY", 24'h0};
      METHOD_OPTIONS:   str = {"OPTIONS", 16'h0};
      METHOD_PRACK:     str = {"PRACK", 32'h0};
      METHOD_PUBLISH:   str = {"PUBLISH", 16'h0};
      METHOD_REFER:     str = {"REFER", 32'h0};
      METHOD_REGISTER:  str = {"REGISTER", 8'h0};
      METHOD_SUBSCRIBE: str = "SUBSCRIBE";
      METHOD_UPDATE:    str = {"UPDATE", 24'h0};
      default:          str = '0;
    endcase
    if (int'(i) < NAME_MAX) begin
      ch = str[8*(NAME_MAX-1-int'(i)) +: 8];
    end else begin
      ch = 8'h00;
    end
    return ch;
  endfunction

  function automatic first_letter_t first_letter(input logic [7:0] c);
    first_letter_t r;
    r.hit = 1'b1;
    case (c)
      "A":     r.code = METHOD_ACK;
      "B":     r.code = METHOD_BYE;
      "C":     r.code = METHOD_CANCEL;
      "I":     r.code = METHOD_INFO;
      "M":     r.code = METHOD_MESSAGE;
      "N":     r.code = METHOD_NOTIFY;
      "O":     r.code = METHOD_OPTIONS;
      "P":     r.code = METHOD_PRACK;
      "R":     r.code = METHOD_REFER;
      "S":     r.code = METHOD_SUBSCRIBE;
      "U":     r.code = METHOD_UPDATE;
      default: begin
        r.hit  = 1'b0;
        r.code = METHOD_ACK;
      end
    endcase
    return r;
  endfunction

endpackage

// ----- sv/smlp_in_stage.sv -----
// ----------------------------------------------------------------------------
// smlp_in_stage
// Input register: captures one header byte beat and holds it for the parser.
// ----------------------------------------------------------------------------
module smlp_in_stage import smlp_pkg::*; #(
  parameter int OFFSET_BITS = DEF_OFFSET_BITS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_valid,
  output logic                   s_ready,
  input  logic [7:0]             s_byte,
  input  logic [OFFSET_BITS-1:0] s_offset,
  input  logic                   s_last,
  output logic                   q_valid,
  input  logic                   q_ready,
  output logic [7:0]             q_byte,
  output logic [OFFSET_BITS-1:0] q_offset,
  output logic                   q_last
);

  assign s_ready = !q_valid || q_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (s_ready) begin
      q_valid <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_valid && s_ready) begin
      q_byte   <= s_byte;
      q_offset <= s_offset;
      q_last   <= s_last;
    end
  end

endmodule

// ----- sv/smlp_parser.sv -----
// ----------------------------------------------------------------------------
// smlp_parser
// Method name matcher: one byte per cycle unless out_ready stalls the result; header state and result register.
// ----------------------------------------------------------------------------
module smlp_parser import smlp_pkg::*; #(
  parameter int MAX_METHODS = DEF_MAX_METHODS,
  parameter int OFFSET_BITS = DEF_OFFSET_BITS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [7:0]             in_byte,
  input  logic [OFFSET_BITS-1:0] first_offset,
  input  logic                   last_byte,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   method_valid,
  output logic [3:0]             method_code,
  output logic [OFFSET_BITS-1:0] method_start,
  output logic [3:0]             method_length,
  output logic                   header_done,
  output logic [1:0]             status,
  output logic [OFFSET_BITS-1:0] error_offset
);

  localparam int CNT_W = $clog2(MAX_METHODS + 1);

  typedef enum logic [1:0] {PH_PRE, PH_NAME, PH_POST, PH_ERR} phase_t;

  phase_t                 phase, phase_next;
  logic [3:0]             current_method, current_method_next;
  logic [3:0]             match_index, match_index_next;
  logic [OFFSET_BITS-1:0] token_start, token_start_next;
  logic [OFFSET_BITS-1:0] byte_position, byte_position_next;
  logic [CNT_W-1:0]       methods_seen, methods_seen_next;
  logic [1:0]             error_status, error_status_next;
  logic [OFFSET_BITS-1:0] error_position, error_position_next;
  logic                   at_start, at_start_next;

  logic [OFFSET_BITS-1:0] cur;
  logic                   lws, comma, start, emit;
  first_letter_t          fl;
  logic                   advance;

  assign in_ready = !out_valid || out_ready;
  assign advance  = in_valid && in_ready;

  always_comb begin
    cur   = at_start ? first_offset : byte_position;
    lws   = (in_byte == CH_SPACE) || (in_byte == CH_TAB) ||
            (in_byte == CH_CR) || (in_byte == CH_LF);
    comma = (in_byte == CH_COMMA);
    fl    = first_letter(in_byte);
    start = 1'b0;
    emit  = 1'b0;

    phase_next          = phase;
    current_method_next = current_method;
    match_index_next    = match_index;
    token_start_next    = token_start;
    methods_seen_next   = methods_seen;
    error_status_next   = error_status;
    error_position_next = error_position;
    at_start_next       = 1'b0;
    byte_position_next  = cur + OFFSET_BITS'(1);

    case (phase)
      PH_PRE: begin
        if (!lws) start = 1'b1;
      end
      PH_NAME: begin
        if (match_index >= name_len(current_method)) begin
          if (lws) begin
            emit       = 1'b1;
            phase_next = PH_POST;
          end else if (comma) begin
            emit       = 1'b1;
            phase_next = PH_PRE;
          end else begin
            error_status_next   = STATUS_INVALID;
            error_position_next = cur;
            phase_next          = PH_ERR;
          end
        end else if (in_byte == name_char(current_method, match_index)) begin
          match_index_next = match_index + 4'd1;
        end else if (current_method == METHOD_INFO && match_index == 4'd2 &&
                     in_byte == CH_V) begin
          current_method_next = METHOD_INVITE;
          match_index_next    = match_index + 4'd1;
        end else if (current_method == METHOD_PRACK && match_index == 4'd1 &&
                     in_byte == CH_U) begin
          current_method_next = METHOD_PUBLISH;
          match_index_next    = match_index + 4'd1;
        end else if (current_method == METHOD_REFER && match_index == 4'd2 &&
                     in_byte == CH_G) begin
          current_method_next = METHOD_REGISTER;
          match_index_next    = match_index + 4'd1;
        end else begin
          error_status_next   = STATUS_INVALID;
          error_position_next = cur;
          phase_next          = PH_ERR;
        end
      end
      PH_POST: begin
        if (comma) begin
          phase_next = PH_PRE;
        end else if (!lws) begin
          start = 1'b1;
        end
      end
      default: ;
    endcase

    if (start) begin
      if (!fl.hit) begin
        error_status_next   = STATUS_INVALID;
        error_position_next = cur;
        phase_next          = PH_ERR;
      end else if (methods_seen >= CNT_W'(MAX_METHODS)) begin
        error_status_next   = STATUS_TOO_MANY;
        error_position_next = cur;
        phase_next          = PH_ERR;
      end else begin
        methods_seen_next   = methods_seen + CNT_W'(1);
        current_method_next = fl.code;
        match_index_next    = 4'd1;
        token_start_next    = cur;
        phase_next          = PH_NAME;
      end
    end

    // Close a name cut off by the end of the header.
    if (last_byte && phase_next == PH_NAME) begin
      if (match_index_next >= name_len(current_method_next)) begin
        emit       = 1'b1;
        phase_next = PH_PRE;
      end else begin
        error_status_next   = STATUS_INVALID;
        error_position_next = cur;
        phase_next          = PH_ERR;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_PRE;
      current_method <= METHOD_ACK;
      match_index    <= '0;
      token_start    <= '0;
      byte_position  <= '0;
      methods_seen   <= '0;
      error_status   <= STATUS_OK;
      error_position <= '0;
      at_start       <= 1'b1;
      out_valid      <= 1'b0;
      method_valid   <= 1'b0;
      method_code    <= '0;
      method_start   <= '0;
      method_length  <= '0;
      header_done    <= 1'b0;
      status         <= STATUS_OK;
      error_offset   <= '0;
    end else begin
      if (advance) begin
        byte_position <= byte_position_next;
        if (last_byte) begin
          phase          <= PH_PRE;
          current_method <= METHOD_ACK;
          match_index    <= '0;
          token_start    <= '0;
          methods_seen   <= '0;
          error_status   <= STATUS_OK;
          error_position <= '0;
          at_start       <= 1'b1;
        end else begin
          phase          <= phase_next;
          current_method <= current_method_next;
          match_index    <= match_index_next;
          token_start    <= token_start_next;
          methods_seen   <= methods_seen_next;
          error_status   <= error_status_next;
          error_position <= error_position_next;
          at_start       <= at_start_next;
        end
        out_valid     <= emit || last_byte;
        method_valid  <= emit;
        method_code   <= emit ? current_method_next : '0;
        method_start  <= emit ? token_start_next : '0;
        method_length <= emit ? match_index_next : '0;
        header_done   <= last_byte;
        status        <= last_byte ? error_status_next : STATUS_OK;
        error_offset  <= (last_byte && error_status_next != STATUS_OK) ?
                         error_position_next : '0;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_len_matches_code: assert property (@(posedge clk) disable iff (rst)
    out_valid && method_valid |-> method_length == name_len(method_code))
    else $error("reported length does not match method code");

  a_name_state: assert property (@(posedge clk) disable iff (rst)
    phase == PH_NAME |-> match_index != 4'd0 && current_method <= METHOD_UPDATE)
    else $error("name phase with bad match state");

  a_error_phase: assert property (@(posedge clk) disable iff (rst)
    error_status != STATUS_OK |-> phase == PH_ERR)
    else $error("error status without error phase");

  a_status_on_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != STATUS_OK |-> header_done)
    else $error("status reported before end of header");

  a_count_limit: assert property (@(posedge clk) disable iff (rst)
    methods_seen <= CNT_W'(MAX_METHODS))
    else $error("method count above limit");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(method_code) && $stable(status))
    else $error("result changed while stalled");

endmodule

// ----- sv/sip_method_list_parser_core.sv -----
// ----------------------------------------------------------------------------
// sip_method_list_parser_core
// SIP Allow header method list parser: matches method names byte by byte.
// ----------------------------------------------------------------------------
// An accepted input beat is registered in the input stage and then in the matcher's result register.
// Throughput: one header byte per cycle while m_axis_tready does not stall the
// result; the name compare and state update of the matcher stage run in the same cycle.
// Reset: synchronous; clears the matcher to the start of a new header and
// empties the input and result registers.
module sip_method_list_parser_core import smlp_pkg::*; #(
  parameter int MAX_METHODS = DEF_MAX_METHODS,
  parameter int OFFSET_BITS = DEF_OFFSET_BITS,
  parameter int IN_W        = ((8 + OFFSET_BITS + 7) / 8) * 8,
  parameter int OUT_W       = ((10 + 2 * OFFSET_BITS + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  // in_byte, first_offset
  input  logic [IN_W-1:0]  s_axis_tdata,
  input  logic             s_axis_tlast,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  // method_code, method_start, method_length, status, error_offset
  output logic [OUT_W-1:0] m_axis_tdata,
  // method_valid
  output logic             m_axis_tuser,
  output logic             m_axis_tlast
);

  localparam int OUT_USED = 10 + 2 * OFFSET_BITS;

  logic                   q_valid, q_ready, q_last;
  logic [7:0]             q_byte;
  logic [OFFSET_BITS-1:0] q_offset;

  logic [3:0]             method_code, method_length;
  logic [OFFSET_BITS-1:0] method_start, error_offset;
  logic [1:0]             status;

  smlp_in_stage #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_in (
    .clk      (clk),
    .rst      (rst),
    .s_valid  (s_axis_tvalid),
    .s_ready  (s_axis_tready),
    .s_byte   (s_axis_tdata[7:0]),
    .s_offset (s_axis_tdata[8 +: OFFSET_BITS]),
    .s_last   (s_axis_tlast),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_byte   (q_byte),
    .q_offset (q_offset),
    .q_last   (q_last)
  );

  smlp_parser #(
    .MAX_METHODS(MAX_METHODS),
    .OFFSET_BITS(OFFSET_BITS)
  ) u_parser (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (q_valid),
    .in_ready      (q_ready),
    .in_byte       (q_byte),
    .first_offset  (q_offset),
    .last_byte     (q_last),
    .out_valid     (m_axis_tvalid),
    .out_ready     (m_axis_tready),
    .method_valid  (m_axis_tuser),
    .method_code   (method_code),
    .method_start  (method_start),
    .method_length (method_length),
    .header_done   (m_axis_tlast),
    .status        (status),
    .error_offset  (error_offset)
  );

  assign m_axis_tdata = OUT_W'(OUT_USED'({error_offset, status, method_length,
                                           method_start, method_code}));

endmodule
